@@ rtl/assert_macros.svh @@
// assertion macros for the ring reader checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ORCR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("orcr assertion failed");

// condition must never be seen
`define ORCR_NEVER(lbl, clk, rstn, cond) \
	`ORCR_ASSERT(lbl, clk, rstn, !(cond))

`endif

@@ rtl/orcr_pkg.sv @@
// shared types and codes for the overwrite ring cursor reader
// no dependencies
package orcr_pkg;

	localparam int CMD_W  = 2;
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;
	localparam int CAP_W  = 7;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam cmd_t CMD_CONSOLE = 2'd0;
	localparam cmd_t CMD_WIRE    = 2'd1;
	localparam cmd_t CMD_READ    = 2'd2;

	localparam kind_t KIND_WIRE   = 2'd0;
	localparam kind_t KIND_RING   = 2'd1;
	localparam kind_t KIND_STATUS = 2'd2;

endpackage

@@ rtl/overwrite_ring_cursor_reader_core.sv @@
// overwrite ring cursor reader, top level: ring memory, write counter, read sequencer
// depends on orcr_pkg
//
// channel   direction  handshake                      payload
// input     in         start & !busy                  command data_byte read_cursor read_capacity
// result    out        strobe, one cycle, no stall    kind out_byte new_cursor lost_count last
// config    in         cfg_wen                        cfg_data (framed mode)
//
// byte writes and wire bytes may come every cycle while busy is low; a wire
// result shows in the cycle after its beat. a read with nonzero capacity holds busy
// through its setup states (oldest, low clamp, high clamp, size) and then while
// its bytes return, one per cycle as set by the single read port of the ring memory.
// reset clears mode, write count and sequencer; ring contents stay undefined.
// the receiver cannot stall, so results never back up.
module overwrite_ring_cursor_reader_core
	import orcr_pkg::*;
#(
	parameter int RING_BYTES = 1024,
	parameter int MAX_READ   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              command,
	input  byte_t             data_byte,
	input  word_t             read_cursor,
	input  logic [CAP_W-1:0]  read_capacity,
	input  logic              cfg_wen,
	input  logic              cfg_data,
	output logic              strobe,
	output kind_t             kind,
	output byte_t             out_byte,
	output word_t             new_cursor,
	output word_t             lost_count,
	output logic              last
);

	localparam int ADDR_W = $clog2(RING_BYTES);
	localparam int CNT_W  = $clog2(MAX_READ + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OLD  = 3'd1;
	localparam logic [2:0] ST_LOW  = 3'd2;
	localparam logic [2:0] ST_HIGH = 3'd3;
	localparam logic [2:0] ST_SIZE = 3'd4;
	localparam logic [2:0] ST_RUN  = 3'd5;

	logic [2:0]        state_q;
	logic              framed_q;
	word_t             wr_q;
	word_t             cur_q;
	word_t             oldest_q;
	word_t             lost_q;
	word_t             fin_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;

	byte_t             ring_q [RING_BYTES];
	byte_t             rdata_q;

	logic              strobe_q;
	logic              from_mem_q;
	kind_t             kind_q;
	byte_t             byte_q;
	word_t             ncur_q;
	word_t             nlost_q;
	logic              last_q;

	logic              accept;
	logic              ring_wr;
	logic [ADDR_W-1:0] rd_addr;
	logic              issue;
	logic              issue_last;
	word_t             avail;
	logic              avail_gt_cap;
	word_t             cap_word;
	logic [CNT_W-1:0]  cap_sat;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign ring_wr    = accept && (command == CMD_CONSOLE) && framed_q;
	assign issue      = (state_q == ST_RUN);
	assign issue_last = (idx_q + CNT_W'(1)) == count_q;
	assign rd_addr    = cur_q[ADDR_W-1:0] + ADDR_W'(idx_q);
	assign cap_word   = WORD_W'(cap_q);
	assign avail      = wr_q - cur_q;
	assign avail_gt_cap = avail > cap_word;
	assign cap_sat    = (read_capacity > CAP_W'(MAX_READ)) ? CNT_W'(MAX_READ)
	                                                       : CNT_W'(read_capacity);

	// ring memory: one write and one registered read a cycle; busy keeps writes out
	// while a read burst is running, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring_q[wr_q[ADDR_W-1:0]] <= data_byte;
		end
		if (issue) begin
			rdata_q <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_q <= 1'b0;
			wr_q     <= '0;
		end else begin
			if (cfg_wen) begin
				framed_q <= cfg_data;
			end
			if (ring_wr) begin
				wr_q <= wr_q + WORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (command == CMD_READ)) begin
						if (read_capacity == '0) begin
							strobe_q <= 1'b1;
						end else begin
							state_q <= ST_OLD;
						end
					end else if (accept && (command == CMD_WIRE ||
					                        (command == CMD_CONSOLE && !framed_q))) begin
						strobe_q <= 1'b1;
					end
				end
				ST_OLD:  state_q <= ST_LOW;
				ST_LOW:  state_q <= ST_HIGH;
				ST_HIGH: state_q <= ST_SIZE;
				ST_SIZE: begin
					if (avail == '0) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					strobe_q <= 1'b1;
					if (issue_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the read sequencer and the result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q      <= read_cursor;
				cap_q      <= cap_sat;
				from_mem_q <= 1'b0;
				last_q     <= 1'b1;
				if (command == CMD_READ) begin
					kind_q  <= KIND_STATUS;
					byte_q  <= '0;
					ncur_q  <= read_cursor;
					nlost_q <= '0;
				end else begin
					kind_q  <= KIND_WIRE;
					byte_q  <= data_byte;
					ncur_q  <= '0;
					nlost_q <= '0;
				end
			end
			ST_OLD: begin
				oldest_q <= (wr_q > WORD_W'(RING_BYTES)) ? wr_q - WORD_W'(RING_BYTES) : '0;
			end
			ST_LOW: begin
				lost_q <= '0;
				if (cur_q - oldest_q >= 32'h8000_0000) begin
					lost_q <= oldest_q - cur_q;
					cur_q  <= oldest_q;
				end
			end
			ST_HIGH: begin
				if (wr_q - cur_q >= 32'h8000_0000) begin
					cur_q <= wr_q;
				end
			end
			ST_SIZE: begin
				idx_q   <= '0;
				count_q <= avail_gt_cap ? cap_q : CNT_W'(avail);
				fin_q   <= avail_gt_cap ? cur_q + cap_word : wr_q;
				kind_q  <= KIND_STATUS;
				byte_q  <= '0;
				ncur_q  <= wr_q;
				nlost_q <= lost_q;
				last_q  <= 1'b1;
			end
			ST_RUN: begin
				idx_q      <= idx_q + CNT_W'(1);
				from_mem_q <= 1'b1;
				kind_q     <= KIND_RING;
				ncur_q     <= fin_q;
				nlost_q    <= lost_q;
				last_q     <= issue_last;
			end
			default: begin
				from_mem_q <= 1'b0;
			end
		endcase
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign out_byte   = from_mem_q ? rdata_q : byte_q;
	assign new_cursor = ncur_q;
	assign lost_count = nlost_q;
	assign last       = last_q;

endmodule

@@ rtl/orcr_checker.sv @@
// port-level checks for the overwrite ring cursor reader, bound to the top level
// depends on orcr_pkg and assert_macros.svh
`include "assert_macros.svh"

module orcr_checker
	import orcr_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  start,
	input logic  busy,
	input cmd_t  command,
	input byte_t data_byte,
	input logic  strobe,
	input kind_t kind,
	input byte_t out_byte,
	input word_t new_cursor,
	input word_t lost_count,
	input logic  last
);

	// wire and status beats are single results
	`ORCR_NEVER(a_single_last, clk, arst_n, strobe && kind != KIND_RING && !last)

	`ORCR_NEVER(a_wire_zero, clk, arst_n,
		strobe && kind == KIND_WIRE && (new_cursor != '0 || lost_count != '0))

	`ORCR_NEVER(a_status_byte, clk, arst_n, strobe && kind == KIND_STATUS && out_byte != '0)

	// a ring burst runs without gaps and keeps its cursor and lost count
	`ORCR_ASSERT(a_burst_cont, clk, arst_n,
		strobe && kind == KIND_RING && !last |=> strobe && kind == KIND_RING &&
		$stable(new_cursor) && $stable(lost_count))

	`ORCR_ASSERT(a_wire_pass, clk, arst_n,
		start && !busy && command == CMD_WIRE |=>
		strobe && kind == KIND_WIRE && out_byte == $past(data_byte))

endmodule

bind overwrite_ring_cursor_reader_core orcr_checker u_orcr_checker (.*);
